// ===== design/ldvbi_pkg.sv =====
// Package for the LaserDisc VBI frame coder: payload structs, code words and
// reciprocal constants for the division-free digit extraction.
// No dependencies.
package ldvbi_pkg;

    typedef struct packed {
        logic [1:0]  area_code;
        logic        picture_mode;
        logic        timecode_mode;
        logic [16:0] picture_value;
        logic [19:0] timecode_frame;
        logic [6:0]  chapter_value;
        logic        amendment_two;
        logic        user_word_valid;
        logic [23:0] user_word;
    } frame_t;

    typedef struct packed {
        logic [23:0] first_line16;
        logic [23:0] first_line17;
        logic [23:0] first_line18;
        logic [23:0] second_line16;
        logic [23:0] second_line17;
        logic [23:0] second_line18;
    } words_t;

    localparam logic [1:0] AREA_PROGRAMME = 2'd0;
    localparam logic [1:0] AREA_LEAD_IN   = 2'd1;
    localparam logic [1:0] AREA_LEAD_OUT  = 2'd2;

    localparam logic [23:0] NO_CODE        = 24'h80DD00;
    localparam logic [23:0] LEAD_IN_CODE   = 24'h88FFFF;
    localparam logic [23:0] LEAD_OUT_CODE  = 24'h80EEEE;
    localparam logic [23:0] CLV_CODE       = 24'h87FFFF;
    localparam logic [23:0] PICTURE_STOP   = 24'h82CFFF;
    localparam logic [23:0] PROG_STATUS    = 24'h8DC000;
    localparam logic [23:0] CHAPTER_BASE   = 24'h880DDD;
    localparam logic [23:0] TIMECODE_BASE  = 24'hF0DD00;

    localparam logic [16:0] MAX_PICTURE_PAL  = 17'd99999;
    localparam logic [16:0] MAX_PICTURE_NTSC = 17'd79999;
    localparam logic [4:0]  FPS_PAL          = 5'd25;
    localparam logic [4:0]  FPS_NTSC         = 5'd30;

    localparam int AMEND_PERIOD = 8991;
    localparam int AMEND_STEP   = 899;

    // Each quotient is (x * RECIP) >> SHIFT with RECIP = ceil(2^SHIFT / d),
    // exact over the full range of x at that point of the pipeline.
    localparam int SHIFT_AMEND = 34;
    localparam logic [20:0] RECIP_AMEND =
        21'(((64'd1 << SHIFT_AMEND) + AMEND_PERIOD - 1) / AMEND_PERIOD);

    localparam int SHIFT_MIN = 31;
    localparam logic [20:0] RECIP_MIN_PAL  = 21'(((64'd1 << SHIFT_MIN) + 1499) / 1500);
    localparam logic [20:0] RECIP_MIN_NTSC = 21'(((64'd1 << SHIFT_MIN) + 1799) / 1800);

    localparam int SHIFT_C100 = 24;
    localparam logic [17:0] RECIP_C100 = 18'(((64'd1 << SHIFT_C100) + 99) / 100);

    localparam int SHIFT_H100 = 17;
    localparam logic [10:0] RECIP_H100 = 11'(((64'd1 << SHIFT_H100) + 99) / 100);

    localparam int SHIFT_C60M = 16;
    localparam logic [10:0] RECIP_C60M = 11'(((64'd1 << SHIFT_C60M) + 59) / 60);

    localparam int SHIFT_STEP = 24;
    localparam logic [14:0] RECIP_STEP =
        15'(((64'd1 << SHIFT_STEP) + AMEND_STEP - 1) / AMEND_STEP);

    localparam int SHIFT_FPS = 26;
    localparam logic [21:0] RECIP_FPS_PAL  = 22'(((64'd1 << SHIFT_FPS) + 24) / 25);
    localparam logic [21:0] RECIP_FPS_NTSC = 22'(((64'd1 << SHIFT_FPS) + 29) / 30);

    localparam int SHIFT_S60 = 22;
    localparam logic [16:0] RECIP_S60 = 17'(((64'd1 << SHIFT_S60) + 59) / 60);

    localparam int SHIFT_10 = 11;
    localparam logic [7:0] RECIP_10 = 8'(((64'd1 << SHIFT_10) + 9) / 10);

endpackage

// ===== design/laserdisc_vbi_frame_coder_unit.sv =====
// Top level of the LaserDisc VBI frame coder: an eight-stage pipeline that turns
// one frame description into the six VBI code words of lines 16 to 18.
// Depends on ldvbi_pkg.
//
// Usage:
// The frame channel (frame_valid, frame_stall, frame) carries one frame
// description per transaction; the words channel (words_valid, words_stall,
// words) returns the six code words for it, in the same order.
// A transaction completes at a rising edge with valid high and stall low.
// words_valid rises once the frame has passed the stage registers 1 to 7 into
// the output register. A new frame is taken every cycle unless frame_stall
// is high; each stage is a register and the slowest path is one reciprocal
// multiply for a constant division.
// Empty stages absorb new frames while the words channel stalls, so the
// frame side stalls only once all eight stages hold a frame. Nothing is lost
// or repeated under stall.
// cfg_wr_en writes video_system (0 PAL, 1 NTSC) from cfg_wr_data; it is
// sampled per frame as it enters and should be written while idle.
// Reset clears all stage valid bits and sets video_system to PAL.
module laserdisc_vbi_frame_coder_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              frame_valid,
    output logic              frame_stall,
    input  ldvbi_pkg::frame_t frame,
    output logic              words_valid,
    input  logic              words_stall,
    output ldvbi_pkg::words_t words
);
    import ldvbi_pkg::*;

    localparam int STAGES = 8;

    typedef struct packed {
        logic [1:0]  area;
        logic        pic_mode;
        logic        tc_mode;
        logic        sys;
        logic        a2en;
        logic        ucv;
        logic [23:0] uc;
        logic [6:0]  ch;
    } ctl_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [19:0] tcf;
        logic [16:0] n;
        logic [6:0]  q_amend;
        logic [9:0]  mins;
        logic [9:0]  n_hi;
    } st1_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [19:0] tcf;
        logic [6:0]  q_amend;
        logic [9:0]  mins;
        logic [9:0]  n_hi;
        logic [13:0] r_amend;
        logic [3:0]  hh;
        logic [6:0]  n_lo;
        logic [3:0]  d4;
    } st2_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [19:0] tcf;
        logic [6:0]  q_amend;
        logic [3:0]  part;
        logic [3:0]  hh;
        logic [5:0]  mm;
        logic [6:0]  n_lo;
        logic [6:0]  n_mid;
        logic [3:0]  d4;
    } st3_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [20:0] cf;
        logic [23:0] cav;
        logic [23:0] tc;
        logic [23:0] chap;
    } st4_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [20:0] cf;
        logic [15:0] secs;
        logic [23:0] cav;
        logic [23:0] tc;
        logic [23:0] chap;
    } st5_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [15:0] secs;
        logic [4:0]  fis;
        logic [9:0]  q60;
        logic [23:0] cav;
        logic [23:0] tc;
        logic [23:0] chap;
    } st6_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [5:0]  s60;
        logic [7:0]  fis_bcd;
        logic [23:0] cav;
        logic [23:0] tc;
        logic [23:0] chap;
    } st7_t;

    function automatic logic [7:0] bcd7(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = 15'(v) * 15'(RECIP_10);
        tens  = prod[SHIFT_10 +: 4];
        units = v - 7'(tens) * 7'd10;
        return {tens, units[3:0]};
    endfunction

    logic                video_system_reg;
    logic [STAGES-1:0]   valid_reg;
    logic [STAGES-1:0]   ready;

    st1_t   st1_reg, st1_next;
    st2_t   st2_reg, st2_next;
    st3_t   st3_reg, st3_next;
    st4_t   st4_reg, st4_next;
    st5_t   st5_reg, st5_next;
    st6_t   st6_reg, st6_next;
    st7_t   st7_reg, st7_next;
    words_t out_reg, out_next;

    logic [16:0] pic_max;
    logic [16:0] pic_clamped;
    logic [20:0] min_recip;
    logic [40:0] amend_prod;
    logic [40:0] min_prod;
    logic [34:0] c100_prod;

    logic [20:0] amend_back;
    logic [20:0] r_wide;
    logic [20:0] hour_prod;
    logic [16:0] n_lo_wide;
    logic [20:0] d4_prod;

    logic [28:0] part_prod;
    logic [4:0]  part_raw;
    logic [9:0]  mm_wide;
    logic [9:0]  n_mid_wide;

    logic [10:0] amend;
    logic [7:0]  ch_bcd;

    logic [21:0] fps_recip;
    logic [42:0] secs_prod;

    logic [4:0]  fps;
    logic [20:0] fis_wide;
    logic [32:0] q60_prod;

    logic [15:0] s60_wide;

    logic [7:0]  s_bcd;
    logic [23:0] clv;
    logic [23:0] lead_code;
    logic [23:0] lead_user;

    always_comb
    begin
        ready[STAGES-1] = !valid_reg[STAGES-1] || !words_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign frame_stall = !ready[0];
    assign words_valid = valid_reg[STAGES-1];
    assign words       = out_reg;

    // Stage 1: clamp the picture number and take the first quotients.
    always_comb
    begin
        pic_max     = video_system_reg ? MAX_PICTURE_NTSC : MAX_PICTURE_PAL;
        pic_clamped = (frame.picture_value > pic_max) ? pic_max : frame.picture_value;
        min_recip   = video_system_reg ? RECIP_MIN_NTSC : RECIP_MIN_PAL;
        amend_prod  = 41'(frame.timecode_frame) * 41'(RECIP_AMEND);
        min_prod    = 41'(frame.timecode_frame) * 41'(min_recip);
        c100_prod   = 35'(pic_clamped) * 35'(RECIP_C100);

        st1_next.ctl.area     = frame.area_code;
        st1_next.ctl.pic_mode = frame.picture_mode;
        st1_next.ctl.tc_mode  = frame.timecode_mode;
        st1_next.ctl.sys      = video_system_reg;
        st1_next.ctl.a2en     = frame.amendment_two & video_system_reg;
        st1_next.ctl.ucv      = frame.user_word_valid;
        st1_next.ctl.uc       = frame.user_word;
        st1_next.ctl.ch       = (frame.chapter_value == 7'd0) ? 7'd1 : frame.chapter_value;
        st1_next.tcf          = frame.timecode_frame;
        st1_next.n            = pic_clamped;
        st1_next.q_amend      = amend_prod[SHIFT_AMEND +: 7];
        st1_next.mins         = min_prod[SHIFT_MIN +: 10];
        st1_next.n_hi         = c100_prod[SHIFT_C100 +: 10];
    end

    // Stage 2: remainders of the first divisions and the hours.
    always_comb
    begin
        amend_back = 21'(st1_reg.q_amend) * 21'(AMEND_PERIOD);
        r_wide     = 21'(st1_reg.tcf) - amend_back;
        hour_prod  = 21'(st1_reg.mins) * 21'(RECIP_C60M);
        n_lo_wide  = st1_reg.n - 17'(st1_reg.n_hi) * 17'd100;
        d4_prod    = 21'(st1_reg.n_hi) * 21'(RECIP_H100);

        st2_next.ctl     = st1_reg.ctl;
        st2_next.tcf     = st1_reg.tcf;
        st2_next.q_amend = st1_reg.q_amend;
        st2_next.mins    = st1_reg.mins;
        st2_next.n_hi    = st1_reg.n_hi;
        st2_next.r_amend = r_wide[13:0];
        st2_next.hh      = hour_prod[SHIFT_C60M +: 4];
        st2_next.n_lo    = n_lo_wide[6:0];
        st2_next.d4      = d4_prod[SHIFT_H100 +: 4];
    end

    // Stage 3: correction step count, minutes and the middle picture digits.
    always_comb
    begin
        part_prod  = 29'(st2_reg.r_amend) * 29'(RECIP_STEP);
        part_raw   = part_prod[SHIFT_STEP +: 5];
        mm_wide    = st2_reg.mins - 10'(st2_reg.hh) * 10'd60;
        n_mid_wide = st2_reg.n_hi - 10'(st2_reg.d4) * 10'd100;

        st3_next.ctl     = st2_reg.ctl;
        st3_next.tcf     = st2_reg.tcf;
        st3_next.q_amend = st2_reg.q_amend;
        st3_next.part    = (part_raw > 5'd9) ? 4'd9 : part_raw[3:0];
        st3_next.hh      = st2_reg.hh;
        st3_next.mm      = mm_wide[5:0];
        st3_next.n_lo    = st2_reg.n_lo;
        st3_next.n_mid   = n_mid_wide[6:0];
        st3_next.d4      = st2_reg.d4;
    end

    // Stage 4: corrected frame count and the picture, timecode and chapter words.
    always_comb
    begin
        amend  = 11'(st3_reg.q_amend) * 11'd10 + 11'(st3_reg.part);
        ch_bcd = bcd7(st3_reg.ctl.ch);

        st4_next.ctl  = st3_reg.ctl;
        st4_next.cf   = 21'(st3_reg.tcf) + (st3_reg.ctl.a2en ? 21'(amend) : 21'd0);
        st4_next.cav  = {4'hF, st3_reg.d4, bcd7(st3_reg.n_mid), bcd7(st3_reg.n_lo)};
        st4_next.tc   = TIMECODE_BASE
                      | {bcd7(7'(st3_reg.hh)), 8'h00, bcd7(7'(st3_reg.mm))};
        st4_next.chap = CHAPTER_BASE | {5'd0, ch_bcd[6:0], 12'd0};
    end

    // Stage 5: seconds of the corrected count.
    always_comb
    begin
        fps_recip = st4_reg.ctl.sys ? RECIP_FPS_NTSC : RECIP_FPS_PAL;
        secs_prod = 43'(st4_reg.cf) * 43'(fps_recip);

        st5_next.ctl  = st4_reg.ctl;
        st5_next.cf   = st4_reg.cf;
        st5_next.secs = secs_prod[SHIFT_FPS +: 16];
        st5_next.cav  = st4_reg.cav;
        st5_next.tc   = st4_reg.tc;
        st5_next.chap = st4_reg.chap;
    end

    // Stage 6: frame within the second and whole minutes of the seconds.
    always_comb
    begin
        fps      = st5_reg.ctl.sys ? FPS_NTSC : FPS_PAL;
        fis_wide = st5_reg.cf - 21'(st5_reg.secs) * 21'(fps);
        q60_prod = 33'(st5_reg.secs) * 33'(RECIP_S60);

        st6_next.ctl  = st5_reg.ctl;
        st6_next.secs = st5_reg.secs;
        st6_next.fis  = fis_wide[4:0];
        st6_next.q60  = q60_prod[SHIFT_S60 +: 10];
        st6_next.cav  = st5_reg.cav;
        st6_next.tc   = st5_reg.tc;
        st6_next.chap = st5_reg.chap;
    end

    // Stage 7: seconds within the minute and the frame digits.
    always_comb
    begin
        s60_wide = st6_reg.secs - 16'(st6_reg.q60) * 16'd60;

        st7_next.ctl     = st6_reg.ctl;
        st7_next.s60     = s60_wide[5:0];
        st7_next.fis_bcd = bcd7(7'(st6_reg.fis));
        st7_next.cav     = st6_reg.cav;
        st7_next.tc      = st6_reg.tc;
        st7_next.chap    = st6_reg.chap;
    end

    // Stage 8: CLV picture word and selection of the six lines.
    always_comb
    begin
        s_bcd     = bcd7(7'(st7_reg.s60));
        clv       = {4'h8, 4'hA + s_bcd[7:4], 4'hE, s_bcd[3:0], st7_reg.fis_bcd};
        lead_code = (st7_reg.ctl.area == AREA_LEAD_IN) ? LEAD_IN_CODE : LEAD_OUT_CODE;
        lead_user = st7_reg.ctl.ucv ? st7_reg.ctl.uc : NO_CODE;

        case (st7_reg.ctl.area)
            AREA_LEAD_IN, AREA_LEAD_OUT:
            begin
                out_next.first_line16  = lead_user;
                out_next.first_line17  = lead_code;
                out_next.first_line18  = lead_code;
                out_next.second_line16 = lead_user;
                out_next.second_line17 = lead_code;
                out_next.second_line18 = lead_code;
            end
            default:
            begin
                if (st7_reg.ctl.pic_mode)
                begin
                    out_next.first_line16  = PROG_STATUS;
                    out_next.first_line17  = st7_reg.cav;
                    out_next.first_line18  = st7_reg.cav;
                    out_next.second_line16 = PICTURE_STOP;
                    out_next.second_line17 = PICTURE_STOP;
                    out_next.second_line18 = st7_reg.chap;
                end
                else if (st7_reg.ctl.tc_mode)
                begin
                    out_next.first_line16  = clv;
                    out_next.first_line17  = st7_reg.tc;
                    out_next.first_line18  = st7_reg.tc;
                    out_next.second_line16 = PROG_STATUS;
                    out_next.second_line17 = CLV_CODE;
                    out_next.second_line18 = st7_reg.chap;
                end
                else
                begin
                    out_next.first_line16  = PROG_STATUS;
                    out_next.first_line17  = NO_CODE;
                    out_next.first_line18  = NO_CODE;
                    out_next.second_line16 = PROG_STATUS;
                    out_next.second_line17 = NO_CODE;
                    out_next.second_line18 = NO_CODE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            video_system_reg <= 1'b0;
            valid_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                video_system_reg <= cfg_wr_data;
            end
            if (ready[0])
            begin
                valid_reg[0] <= frame_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0] && frame_valid)
        begin
            st1_reg <= st1_next;
        end
        if (ready[1] && valid_reg[0])
        begin
            st2_reg <= st2_next;
        end
        if (ready[2] && valid_reg[1])
        begin
            st3_reg <= st3_next;
        end
        if (ready[3] && valid_reg[2])
        begin
            st4_reg <= st4_next;
        end
        if (ready[4] && valid_reg[3])
        begin
            st5_reg <= st5_next;
        end
        if (ready[5] && valid_reg[4])
        begin
            st6_reg <= st6_next;
        end
        if (ready[6] && valid_reg[5])
        begin
            st7_reg <= st7_next;
        end
        if (ready[7] && valid_reg[6])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== tb/ldvbi_words_check.sv =====
// Watches both channels and the configuration port of the LaserDisc VBI frame coder,
// predicts the six code words of every accepted frame and compares them in order.
// Depends on ldvbi_pkg.
module ldvbi_words_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              frame_valid,
    input  logic              frame_stall,
    input  ldvbi_pkg::frame_t frame,
    input  logic              words_valid,
    input  logic              words_stall,
    input  ldvbi_pkg::words_t words,
    output int                mismatch_count,
    output int                words_pending
);
    import ldvbi_pkg::*;

    localparam logic [23:0] CAV_PICTURE_BASE = 24'hF00000;
    localparam logic [23:0] CLV_PICTURE_BASE = 24'h80E000;
    localparam logic [3:0]  CLV_TENS_BASE    = 4'hA;

    words_t words_due[$];
    logic   ntsc_mode;

    function automatic int unsigned to_bcd2(int unsigned v);
        return ((v / 10) << 4) | (v % 10);
    endfunction

    function automatic words_t encode_vbi_words(frame_t f, logic ntsc);
        int unsigned fps;
        int unsigned chap;
        int unsigned pic;
        int unsigned cap;
        int unsigned count;
        int unsigned mins;
        int unsigned shifted;
        int unsigned step;
        int unsigned secs;
        int unsigned s60;
        logic [23:0] lead_word;
        logic [23:0] chap_word;
        logic [23:0] cav;
        logic [23:0] clv;
        logic [23:0] tc;
        words_t w;
        fps = ntsc ? FPS_NTSC : FPS_PAL;
        w.first_line16  = NO_CODE;
        w.first_line17  = NO_CODE;
        w.first_line18  = NO_CODE;
        w.second_line16 = NO_CODE;
        w.second_line17 = NO_CODE;
        w.second_line18 = NO_CODE;
        if (f.area_code == AREA_LEAD_IN || f.area_code == AREA_LEAD_OUT)
        begin
            lead_word = (f.area_code == AREA_LEAD_IN) ? LEAD_IN_CODE : LEAD_OUT_CODE;
            if (f.user_word_valid)
            begin
                w.first_line16  = f.user_word;
                w.second_line16 = f.user_word;
            end
            w.first_line17  = lead_word;
            w.first_line18  = lead_word;
            w.second_line17 = lead_word;
            w.second_line18 = lead_word;
        end
        else
        begin
            chap = (f.chapter_value == 0) ? 1 : f.chapter_value;
            chap_word = CHAPTER_BASE | 24'((to_bcd2(chap) & 32'h7F) << 12);
            if (f.picture_mode)
            begin
                cap = ntsc ? MAX_PICTURE_NTSC : MAX_PICTURE_PAL;
                pic = f.picture_value;
                if (pic > cap)
                    pic = cap;
                cav = CAV_PICTURE_BASE | 24'({4'(pic / 10000 % 10), 4'(pic / 1000 % 10),
                    4'(pic / 100 % 10), 4'(pic / 10 % 10), 4'(pic % 10)});
                w.first_line16  = PROG_STATUS;
                w.first_line17  = cav;
                w.first_line18  = cav;
                w.second_line16 = PICTURE_STOP;
                w.second_line17 = PICTURE_STOP;
                w.second_line18 = chap_word;
            end
            else if (f.timecode_mode)
            begin
                count = f.timecode_frame;
                mins = count / fps / 60;
                shifted = count;
                if (f.amendment_two && ntsc)
                begin
                    step = (count % AMEND_PERIOD) / AMEND_STEP;
                    if (step > 9)
                        step = 9;
                    shifted = count + 10 * (count / AMEND_PERIOD) + step;
                end
                secs = shifted / fps;
                s60 = secs % 60;
                clv = CLV_PICTURE_BASE | 24'((CLV_TENS_BASE + s60 / 10) << 16)
                    | 24'((s60 % 10) << 8) | 24'(to_bcd2(shifted % fps));
                tc = TIMECODE_BASE | 24'(to_bcd2(mins / 60) << 16) | 24'(to_bcd2(mins % 60));
                w.first_line16  = clv;
                w.first_line17  = tc;
                w.first_line18  = tc;
                w.second_line16 = PROG_STATUS;
                w.second_line17 = CLV_CODE;
                w.second_line18 = chap_word;
            end
            else
            begin
                w.first_line16  = PROG_STATUS;
                w.second_line16 = PROG_STATUS;
            end
        end
        return w;
    endfunction

    task automatic check_word(string field, logic [23:0] want, logic [23:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, actual %h", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        words_t want;
        if (!rst_n)
        begin
            ntsc_mode = 1'b0;
            words_due.delete();
        end
        else
        begin
            if (words_valid && !words_stall)
            begin
                if (words_due.size() == 0)
                begin
                    $error("words transaction with no frame outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = words_due.pop_front();
                    check_word("first_line16", want.first_line16, words.first_line16);
                    check_word("first_line17", want.first_line17, words.first_line17);
                    check_word("first_line18", want.first_line18, words.first_line18);
                    check_word("second_line16", want.second_line16, words.second_line16);
                    check_word("second_line17", want.second_line17, words.second_line17);
                    check_word("second_line18", want.second_line18, words.second_line18);
                end
            end
            if (frame_valid && !frame_stall)
                words_due = {words_due, encode_vbi_words(frame, ntsc_mode)};
            if (cfg_wr_en)
                ntsc_mode = cfg_wr_data;
        end
        words_pending = words_due.size();
    end

endmodule

// ===== tb/laserdisc_vbi_frame_coder_unit_test.sv =====
// Top of the LaserDisc VBI frame coder testbench: clock, reset, frame stimulus,
// words-side stall, video system writes, watchdog and verdict.
// Depends on ldvbi_pkg, ldvbi_words_check and laserdisc_vbi_frame_coder_unit.
module laserdisc_vbi_frame_coder_unit_test;
    import ldvbi_pkg::*;

    localparam logic [1:0] AREA_UNUSED = 2'd3;
    localparam logic       VIDEO_PAL   = 1'b0;
    localparam logic       VIDEO_NTSC  = 1'b1;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 40;
    localparam int DRAIN_CYCLES = 16;

    logic   clk;
    logic   rst_n;
    logic   cfg_wr_en;
    logic   cfg_wr_data;
    logic   frame_valid;
    logic   frame_stall;
    frame_t frame_in;
    logic   words_valid;
    logic   words_stall;
    words_t words_out;
    int     mismatch_count;
    int     words_pending;
    int     send_idle_pct;
    int     recv_idle_pct;
    logic   hold_request;
    int     idle_cycles;

    laserdisc_vbi_frame_coder_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame_in),
        .words_valid (words_valid),
        .words_stall (words_stall),
        .words       (words_out)
    );

    ldvbi_words_check u_words_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .frame          (frame_in),
        .words_valid    (words_valid),
        .words_stall    (words_stall),
        .words          (words_out),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic frame_t random_frame();
        frame_t f;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            f.area_code = AREA_PROGRAMME;
        else if (pick < 82)
            f.area_code = AREA_LEAD_IN;
        else if (pick < 94)
            f.area_code = AREA_LEAD_OUT;
        else
            f.area_code = AREA_UNUSED;
        f.picture_mode  = 1'($urandom_range(0, 1));
        f.timecode_mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: f.picture_value = 17'($urandom_range(0, 131071));
            1: f.picture_value = 17'($urandom_range(79990, 80010));
            2: f.picture_value = 17'($urandom_range(99990, 100010));
            default: f.picture_value = 17'($urandom_range(0, 99999));
        endcase
        case ($urandom_range(0, 2))
            0: f.timecode_frame = 20'($urandom());
            1: f.timecode_frame = 20'($urandom_range(0, 115) * AMEND_PERIOD
                + $urandom_range(0, 10) * AMEND_STEP + $urandom_range(0, 2));
            default: f.timecode_frame = 20'($urandom_range(0, 899999));
        endcase
        f.chapter_value   = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(0, 127));
        f.amendment_two   = 1'($urandom_range(0, 1));
        f.user_word_valid = 1'($urandom_range(0, 1));
        f.user_word       = 24'($urandom());
        return f;
    endfunction

    task automatic send_frame(frame_t f);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            frame_valid <= 1'b0;
            @(negedge clk);
        end
        frame_valid <= 1'b1;
        frame_in    <= f;
        do
            @(posedge clk);
        while (frame_stall);
    endtask

    task automatic drain_frames();
        @(negedge clk);
        frame_valid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
    endtask

    task automatic set_video_system(logic ntsc);
        drain_frames();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ntsc;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_directed();
        frame_t plan[12];
        plan[0]  = '{AREA_PROGRAMME, 1'b0, 1'b0, 17'd0, 20'd0, 7'd0, 1'b0, 1'b0, 24'h000000};
        plan[1]  = '{AREA_LEAD_IN, 1'b0, 1'b0, 17'd0, 20'd0, 7'd0, 1'b0, 1'b1, 24'hFFFFFF};
        plan[2]  = '{AREA_LEAD_OUT, 1'b1, 1'b1, 17'h1FFFF, 20'hFFFFF, 7'h7F, 1'b1, 1'b0,
                     24'h000000};
        plan[3]  = '{AREA_UNUSED, 1'b1, 1'b0, 17'd0, 20'd0, 7'd0, 1'b0, 1'b1, 24'h5A5A5A};
        plan[4]  = '{AREA_PROGRAMME, 1'b1, 1'b0, 17'h1FFFF, 20'd0, 7'd127, 1'b0, 1'b0,
                     24'h000000};
        plan[5]  = '{AREA_PROGRAMME, 1'b1, 1'b0, 17'd79999, 20'd0, 7'd79, 1'b0, 1'b0,
                     24'h000000};
        plan[6]  = '{AREA_PROGRAMME, 1'b1, 1'b1, 17'd99999, 20'hFFFFF, 7'd99, 1'b1, 1'b1,
                     24'hA5A5A5};
        plan[7]  = '{AREA_PROGRAMME, 1'b0, 1'b1, 17'd0, 20'd0, 7'd0, 1'b1, 1'b0, 24'h000000};
        plan[8]  = '{AREA_PROGRAMME, 1'b0, 1'b1, 17'd0, 20'hFFFFF, 7'd100, 1'b1, 1'b0,
                     24'h000000};
        plan[9]  = '{AREA_PROGRAMME, 1'b0, 1'b1, 17'd0, 20'd8990, 7'd1, 1'b1, 1'b0, 24'h000000};
        plan[10] = '{AREA_PROGRAMME, 1'b0, 1'b1, 17'd0, 20'd899999, 7'd79, 1'b0, 1'b0,
                     24'h000000};
        plan[11] = '{AREA_LEAD_OUT, 1'b0, 1'b0, 17'd0, 20'd0, 7'd0, 1'b0, 1'b1, 24'h0F0F0F};
        foreach (plan[i])
            send_frame(plan[i]);
    endtask

    task automatic run_random(int count, int send_pct, int recv_pct, bit with_hold);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            if (with_hold && i == 50)
                hold_request = 1'b1;
            send_frame(random_frame());
        end
    endtask

    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        words_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                words_stall <= 1'b1;
                hold_left--;
            end
            else
                words_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((frame_valid && !frame_stall) || (words_valid && !words_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        hold_request  = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 69;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        frame_valid <= 1'b0;
        frame_in    <= '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_video_system(VIDEO_PAL);
        run_directed();
        set_video_system(VIDEO_NTSC);
        run_directed();
        run_random(380, 10, 69, 1'b0);
        set_video_system(VIDEO_PAL);
        run_random(380, 69, 10, 1'b0);
        set_video_system(VIDEO_NTSC);
        run_random(390, 0, 0, 1'b1);

        drain_frames();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
